// ===== rtl/core/htmc_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// htmc_pkg: shared types and constants of the heater timer menu controller
// Payload structs, operation and reply codes, menu items, register indexes
// and the fixed-point reciprocals used for the display split.
// ============================================================================
package htmc_pkg;

    // operation codes of an input item
    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_STEP  = 3'd1;
    localparam logic [2:0] OP_BTN   = 3'd2;
    localparam logic [2:0] OP_ON    = 3'd3;
    localparam logic [2:0] OP_OFF   = 3'd4;
    localparam logic [2:0] OP_ADD   = 3'd5;

    // remote reply codes
    localparam logic [2:0] REPLY_NONE    = 3'd0;
    localparam logic [2:0] REPLY_ON      = 3'd1;
    localparam logic [2:0] REPLY_ALREADY = 3'd2;
    localparam logic [2:0] REPLY_OFF     = 3'd3;
    localparam logic [2:0] REPLY_OK      = 3'd4;

    // menu items
    localparam logic [1:0] MENU_START = 2'd0;
    localparam logic [1:0] MENU_STOP  = 2'd1;
    localparam logic [1:0] MENU_SET   = 2'd2;
    localparam logic [1:0] MENU_SHOW  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_MAX_MINUTES = 2'd0;
    localparam logic [1:0] CFG_ON_MINUTES  = 2'd1;
    localparam logic [1:0] CFG_ADD_MINUTES = 2'd2;

    // register reset values
    localparam logic [7:0] MAX_MINUTES_RST = 8'd90;
    localparam logic [7:0] ON_MINUTES_RST  = 8'd90;
    localparam logic [7:0] ADD_MINUTES_RST = 8'd15;

    localparam logic [23:0] MS_PER_MINUTE = 24'd60000;
    localparam logic [14:0] SEC_PER_MINUTE = 15'd60;

    // exact reciprocals for a 24-bit numerator: floor(r * M / 2^k)
    localparam logic [24:0] RECIP_MIN = 25'd18325194;   // ceil(2^40 / 60000)
    localparam int          SHIFT_MIN = 40;
    localparam logic [24:0] RECIP_SEC = 25'd17179870;   // ceil(2^34 / 1000)
    localparam int          SHIFT_SEC = 34;

    typedef struct packed {
        logic [2:0] operation;
        logic       step_up;
        logic       button_level;
        logic [9:0] elapsed_ms;
    } in_item_t;

    typedef struct packed {
        logic        heater_drive;
        logic [23:0] remaining_ms;
        logic [7:0]  minutes_left;
        logic [5:0]  seconds_left;
        logic [1:0]  menu_item;
        logic        in_set_mode;
        logic [7:0]  set_value;
        logic        show_address;
        logic [2:0]  remote_reply;
    } out_item_t;

endpackage

// ===== rtl/core/heater_timer_menu_controller.sv =====
`timescale 1ns / 1ps
// ============================================================================
// heater_timer_menu_controller: timed heater with menu and remote commands
// Every input item updates the controller state and yields one result item
// showing the state after that item.
// ============================================================================
//
// Input channel in_valid/in_ready/in_data carries ticks (elapsed ms), encoder
// steps, button level samples and remote on/off/add commands. Every accepted
// item yields exactly one result on out_valid/out_ready/out_data, in order.
// The controller state is updated at the edge where the item transfers, so a
// new item can transfer in every cycle while the receiver takes results: one
// item per cycle sustained. An item then passes three registered stages: a
// snapshot stage, a stage of two constant reciprocal multipliers (minutes
// and whole seconds of the remaining time), and a stage forming the seconds
// field.
// When the receiver stalls, the three stages keep filling and in_ready drops
// only once all three hold a result; a bubble anywhere lets input through.
// The cfg_write port writes max, remote-on or add minutes, one register per
// cycle; the user must use it only while no item is in flight (not enforced).
// Reset: heater off, zero remaining time, start item, set mode off, set
// value 0, button released, registers at 90/90/15 minutes, pipeline empty.
//
module heater_timer_menu_controller
    import htmc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data,
    input  logic      cfg_write,
    input  logic [1:0] cfg_addr,
    input  logic [7:0] cfg_wdata
);

    // configuration registers and their millisecond products
    logic [7:0]  max_minutes_reg;
    logic [23:0] cap_ms_reg;
    logic [23:0] on_ms_reg;
    logic [23:0] add_ms_reg;
    logic [23:0] cfg_ms;

    // controller state
    logic        heater_reg,   heater_next;
    logic [23:0] remain_reg,   remain_next;
    logic [1:0]  menu_reg,     menu_next;
    logic        set_mode_reg, set_mode_next;
    logic [7:0]  chosen_reg,   chosen_next;
    logic        prev_btn_reg, prev_btn_next;
    logic        show_next;
    logic [2:0]  reply_next;

    // pipeline
    logic        v1_reg, v2_reg, v3_reg;
    logic        en1, en2, en3;
    logic        accept;
    out_item_t   s1_reg, s1_next;
    out_item_t   s2_reg, s2_next;
    out_item_t   s3_reg, s3_next;
    logic [14:0] t_sec_reg;
    logic [48:0] prod_min;
    logic [48:0] prod_sec;
    logic [14:0] sec_full;

    // working values
    logic [8:0]  chosen_inc;
    logic [23:0] elapsed_ext;
    logic [24:0] add_sum;
    logic        btn_fall;

    // stage enables, a stage loads when it is empty or its successor loads
    assign en3      = ~v3_reg | out_ready;
    assign en2      = ~v2_reg | en3;
    assign en1      = ~v1_reg | en2;
    assign in_ready = en1;
    assign accept   = in_valid & in_ready;

    // config write
    assign cfg_ms = 24'(cfg_wdata) * MS_PER_MINUTE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_minutes_reg <= MAX_MINUTES_RST;
            cap_ms_reg      <= 24'(MAX_MINUTES_RST) * MS_PER_MINUTE;
            on_ms_reg       <= 24'(ON_MINUTES_RST) * MS_PER_MINUTE;
            add_ms_reg      <= 24'(ADD_MINUTES_RST) * MS_PER_MINUTE;
        end
        else if (cfg_write)
        begin
            case (cfg_addr)
                CFG_MAX_MINUTES:
                begin
                    max_minutes_reg <= cfg_wdata;
                    cap_ms_reg      <= cfg_ms;
                end
                CFG_ON_MINUTES:
                begin
                    on_ms_reg <= cfg_ms;
                end
                CFG_ADD_MINUTES:
                begin
                    add_ms_reg <= cfg_ms;
                end
                default:
                begin
                end
            endcase
        end
    end

    // event handling
    assign chosen_inc  = {1'b0, chosen_reg} + 9'd1;
    assign elapsed_ext = {14'd0, in_data.elapsed_ms};
    assign add_sum     = {1'b0, remain_reg} + {1'b0, add_ms_reg};
    assign btn_fall    = prev_btn_reg & ~in_data.button_level;

    always_comb
    begin
        heater_next   = heater_reg;
        remain_next   = remain_reg;
        menu_next     = menu_reg;
        set_mode_next = set_mode_reg;
        chosen_next   = chosen_reg;
        prev_btn_next = prev_btn_reg;
        show_next     = 1'b0;
        reply_next    = REPLY_NONE;
        if (accept)
        begin
            case (in_data.operation)
                OP_TICK:
                begin
                    if (heater_reg && (remain_reg != 24'd0))
                    begin
                        if (elapsed_ext >= remain_reg)
                        begin
                            remain_next = 24'd0;
                            heater_next = 1'b0;
                        end
                        else
                        begin
                            remain_next = remain_reg - elapsed_ext;
                        end
                    end
                end
                OP_STEP:
                begin
                    if (set_mode_reg)
                    begin
                        if (in_data.step_up)
                            chosen_next = (chosen_inc > {1'b0, max_minutes_reg}) ?
                                          8'd0 : chosen_inc[7:0];
                        else if (chosen_reg == 8'd0)
                            chosen_next = max_minutes_reg;
                        else
                            chosen_next = chosen_reg - 8'd1;
                    end
                    else if (in_data.step_up)
                    begin
                        menu_next = menu_reg + 2'd1;
                    end
                    else
                    begin
                        menu_next = menu_reg - 2'd1;
                    end
                end
                OP_BTN:
                begin
                    if (btn_fall)
                    begin
                        if (set_mode_reg)
                        begin
                            remain_next   = 24'(chosen_reg) * MS_PER_MINUTE;
                            set_mode_next = 1'b0;
                        end
                        else
                        begin
                            case (menu_reg)
                                MENU_START:
                                    if (!heater_reg && (remain_reg != 24'd0))
                                        heater_next = 1'b1;
                                MENU_STOP:
                                    heater_next = 1'b0;
                                MENU_SET:
                                    if (!heater_reg)
                                        set_mode_next = 1'b1;
                                MENU_SHOW:
                                    show_next = 1'b1;
                                default:
                                    show_next = 1'b0;
                            endcase
                        end
                    end
                    prev_btn_next = in_data.button_level;
                end
                OP_ON:
                begin
                    if (remain_reg == 24'd0)
                    begin
                        remain_next = on_ms_reg;
                        heater_next = 1'b1;
                        reply_next  = REPLY_ON;
                    end
                    else
                    begin
                        reply_next = REPLY_ALREADY;
                    end
                end
                OP_OFF:
                begin
                    heater_next = 1'b0;
                    remain_next = 24'd0;
                    reply_next  = REPLY_OFF;
                end
                OP_ADD:
                begin
                    remain_next = (add_sum > {1'b0, cap_ms_reg}) ?
                                  cap_ms_reg : add_sum[23:0];
                    reply_next  = REPLY_OK;
                end
                default:
                begin
                    reply_next = REPLY_NONE;
                end
            endcase
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heater_reg   <= 1'b0;
            remain_reg   <= 24'd0;
            menu_reg     <= MENU_START;
            set_mode_reg <= 1'b0;
            chosen_reg   <= 8'd0;
            prev_btn_reg <= 1'b1;
        end
        else
        begin
            heater_reg   <= heater_next;
            remain_reg   <= remain_next;
            menu_reg     <= menu_next;
            set_mode_reg <= set_mode_next;
            chosen_reg   <= chosen_next;
            prev_btn_reg <= prev_btn_next;
        end
    end

    // snapshot of the state after the event
    always_comb
    begin
        s1_next              = '0;
        s1_next.heater_drive = heater_next;
        s1_next.remaining_ms = remain_next;
        s1_next.menu_item    = menu_next;
        s1_next.in_set_mode  = set_mode_next;
        s1_next.set_value    = chosen_next;
        s1_next.show_address = show_next;
        s1_next.remote_reply = reply_next;
    end

    // reciprocal multiplies for minutes and whole seconds
    assign prod_min = 49'(s1_reg.remaining_ms) * 49'(RECIP_MIN);
    assign prod_sec = 49'(s1_reg.remaining_ms) * 49'(RECIP_SEC);

    always_comb
    begin
        s2_next              = s1_reg;
        s2_next.minutes_left = prod_min[SHIFT_MIN +: 8];
    end

    // seconds within the minute
    assign sec_full = t_sec_reg - 15'(s2_reg.minutes_left) * SEC_PER_MINUTE;

    always_comb
    begin
        s3_next              = s2_reg;
        s3_next.seconds_left = sec_full[5:0];
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= accept;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (en1)
            s1_reg <= s1_next;
        if (en2)
        begin
            s2_reg    <= s2_next;
            t_sec_reg <= 15'(prod_sec >> SHIFT_SEC);
        end
        if (en3)
            s3_reg <= s3_next;
    end

    assign out_valid = v3_reg;
    assign out_data  = s3_reg;

    // checks
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (v1_reg && v2_reg && v3_reg))
        else $error("input stalled with a free stage");

    a_seconds_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.seconds_left < 6'd60))
        else $error("seconds field out of range");

    a_minutes_split: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.remaining_ms >=
                       24'(out_data.minutes_left) * MS_PER_MINUTE))
        else $error("minutes field exceeds remaining time");

    a_remote_off: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_data.operation == OP_OFF)) |=>
            (!heater_reg && (remain_reg == 24'd0)))
        else $error("remote off left heater running");

endmodule
